>>> rtl/itp_pkg.sv
// Shared types, codes and helper functions of the infix-to-postfix converter.
package itp_pkg;

  localparam int STACK_DEPTH_DEFAULT = 16;
  localparam int OPERATOR_COUNT      = 8;

  // Stack entry that marks an open paren
  localparam logic [3:0] PAREN_MARK = 4'd8;

  // Token commands
  localparam logic [2:0] CMD_OPERAND  = 3'd0;
  localparam logic [2:0] CMD_OPERATOR = 3'd1;
  localparam logic [2:0] CMD_OPEN     = 3'd2;
  localparam logic [2:0] CMD_CLOSE    = 3'd3;
  localparam logic [2:0] CMD_END      = 3'd4;

  // Expression status codes
  localparam logic [2:0] ST_RUNNING  = 3'd0;
  localparam logic [2:0] ST_COMPLETE = 3'd1;
  localparam logic [2:0] ST_MISSING  = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_UNCLOSED = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] REG_PRIORITY = 2'd0;
  localparam logic [1:0] REG_UNARY    = 2'd1;
  localparam logic [1:0] REG_BINARY   = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  operator_index;
    logic [31:0] operand_value;
  } token_t;

  typedef struct packed {
    logic        has_node;
    logic        node_is_operator;
    logic [31:0] node_value;
    logic [2:0]  status;
    logic        token_consumed;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPERAND,
    S_STATUS,
    S_PUSH,
    S_POP_RD,
    S_POP_DO
  } state_t;

  typedef enum logic [1:0] {
    PM_FINISH,
    PM_BIN,
    PM_CLOSE,
    PM_PAREN
  } pop_mode_t;

  // Four-bit priority of an operator index
  function automatic logic [3:0] prio_of(input logic [31:0] table_word,
                                         input logic [2:0]  idx);
    prio_of = table_word[{idx, 2'b00} +: 4];
  endfunction

  // Operator index allowed by a mask
  function automatic logic op_valid(input logic [7:0] mask, input logic [2:0] idx);
    op_valid = (int'(idx) < OPERATOR_COUNT) && mask[idx];
  endfunction

endpackage

>>> rtl/infix_to_postfix_converter.sv
// Top level of the shunting-yard infix-to-postfix converter.
// Tokens are taken one at a time: in_stall is high while a token is being
// worked on. An operand, a push or a status-only outcome is accepted in
// S_IDLE and then handled in its action state. Each entry popped from the
// stack passes through S_POP_RD, which reads the entry below it from the
// stack RAM with its registered read port, and S_POP_DO, which emits the
// node. A close paren in operator position pops every entry down to and
// including the open paren, which is dropped without a node. Unknown
// commands are accepted and dropped without a result. A single priority
// comparator, shared by a binary operator's first pop decision and every
// later one, decides its popping. Results pass through an output register,
// so a stalled result holds the sequencer only when a further result must
// be sent. Configuration is written over the cfg port, which is always ready.
module infix_to_postfix_converter
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  token_t      in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output result_t     out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  // Configuration registers
  logic [31:0] prio_table;
  logic [7:0]  unary_mask;
  logic [7:0]  binary_mask;

  // Sequencer state
  state_t    state, state_next;
  pop_mode_t mode, mode_next;
  token_t    tok, tok_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] open_cnt, open_cnt_next;
  logic          expect_op, expect_op_next;
  logic [3:0]    top, top_next;
  logic [2:0]    st_code, st_code_next;
  logic          consumed, consumed_next;
  logic [3:0]    push_val, push_val_next;
  logic          push_expect, push_expect_next;

  // Stack RAM access
  logic          wr_en;
  logic          rd_en;
  logic [3:0]    rd_data;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;

  // Output side
  logic    out_load;
  logic    out_rdy;
  result_t out_word;

  // Shared priority comparator
  logic [3:0] cmp_top;
  logic [2:0] cur_idx;
  logic       pop_ok;

  // Finish decision
  logic       fin_pop;
  logic [2:0] fin_code;

  logic in_take;
  logic more;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && (state == S_IDLE);
  assign cnt_m1    = count - CW'(1);
  assign cnt_m2    = count - CW'(2);
  assign more      = (count > CW'(1));

  // Compare the entry in view against the incoming operator
  assign cmp_top = (state == S_POP_DO) ? rd_data : top;
  assign cur_idx = (state == S_IDLE) ? in_data.operator_index : tok.operator_index;
  assign pop_ok  = (cmp_top != PAREN_MARK) &&
                   (prio_of(prio_table, cmp_top[2:0]) <= prio_of(prio_table, cur_idx));

  // Ending an expression: errors first, then drain the stack
  always_comb begin
    fin_pop  = 1'b0;
    fin_code = ST_COMPLETE;
    if (expect_op) begin
      fin_code = ST_MISSING;
    end else if (open_cnt != '0) begin
      fin_code = ST_UNCLOSED;
    end else if (count != '0) begin
      fin_pop = 1'b1;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      prio_table  <= '0;
      unary_mask  <= '0;
      binary_mask <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PRIORITY: prio_table  <= cfg_data;
        REG_UNARY:    unary_mask  <= cfg_data[7:0];
        REG_BINARY:   binary_mask <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer: next state and outputs
  always_comb begin
    state_next       = state;
    mode_next        = mode;
    tok_next         = tok;
    count_next       = count;
    open_cnt_next    = open_cnt;
    expect_op_next   = expect_op;
    top_next         = top;
    st_code_next     = st_code;
    consumed_next    = consumed;
    push_val_next    = push_val;
    push_expect_next = push_expect;
    wr_en            = 1'b0;
    rd_en            = 1'b0;
    out_load         = 1'b0;
    out_word         = '0;

    case (state)
      S_IDLE: begin
        if (in_take) begin
          tok_next         = in_data;
          consumed_next    = 1'b1;
          push_expect_next = 1'b0;
          push_val_next    = {1'b0, in_data.operator_index};
          if (expect_op) begin
            case (in_data.command)
              CMD_OPERAND: state_next = S_OPERAND;
              CMD_OPERATOR: begin
                if (!op_valid(unary_mask, in_data.operator_index)) begin
                  st_code_next = ST_MISSING;
                  state_next   = S_STATUS;
                end else if (count == FULL) begin
                  st_code_next = ST_OVERFLOW;
                  state_next   = S_STATUS;
                end else begin
                  state_next = S_PUSH;
                end
              end
              CMD_OPEN: begin
                if (count == FULL) begin
                  st_code_next = ST_OVERFLOW;
                  state_next   = S_STATUS;
                end else begin
                  push_val_next = PAREN_MARK;
                  open_cnt_next = open_cnt + CW'(1);
                  state_next    = S_PUSH;
                end
              end
              CMD_CLOSE: begin
                if (open_cnt == '0) begin
                  consumed_next = 1'b0;
                  mode_next     = PM_FINISH;
                  st_code_next  = fin_code;
                  state_next    = fin_pop ? S_POP_RD : S_STATUS;
                end else if (count != '0 && top == PAREN_MARK) begin
                  st_code_next = ST_EMPTY;
                  state_next   = S_STATUS;
                end else begin
                  st_code_next = ST_MISSING;
                  state_next   = S_STATUS;
                end
              end
              CMD_END: begin
                mode_next    = PM_FINISH;
                st_code_next = fin_code;
                state_next   = fin_pop ? S_POP_RD : S_STATUS;
              end
              default: ;
            endcase
          end else begin
            case (in_data.command)
              CMD_OPERATOR: begin
                if (!op_valid(binary_mask, in_data.operator_index)) begin
                  consumed_next = 1'b0;
                  mode_next     = PM_FINISH;
                  st_code_next  = fin_code;
                  state_next    = fin_pop ? S_POP_RD : S_STATUS;
                end else if (count != '0 && pop_ok) begin
                  push_expect_next = 1'b1;
                  mode_next        = PM_BIN;
                  state_next       = S_POP_RD;
                end else if (count == FULL) begin
                  st_code_next = ST_OVERFLOW;
                  state_next   = S_STATUS;
                end else begin
                  push_expect_next = 1'b1;
                  state_next       = S_PUSH;
                end
              end
              CMD_CLOSE: begin
                if (open_cnt == '0) begin
                  consumed_next = 1'b0;
                  mode_next     = PM_FINISH;
                  st_code_next  = fin_code;
                  state_next    = fin_pop ? S_POP_RD : S_STATUS;
                end else begin
                  mode_next  = (count != '0 && top != PAREN_MARK) ? PM_CLOSE : PM_PAREN;
                  state_next = S_POP_RD;
                end
              end
              CMD_END: begin
                mode_next    = PM_FINISH;
                st_code_next = fin_code;
                state_next   = fin_pop ? S_POP_RD : S_STATUS;
              end
              CMD_OPERAND, CMD_OPEN: begin
                consumed_next = 1'b0;
                mode_next     = PM_FINISH;
                st_code_next  = fin_code;
                state_next    = fin_pop ? S_POP_RD : S_STATUS;
              end
              default: ;
            endcase
          end
        end
      end

      // Emit the operand node
      S_OPERAND: begin
        if (out_rdy) begin
          out_load                  = 1'b1;
          out_word.has_node         = 1'b1;
          out_word.node_value       = tok.operand_value;
          out_word.status           = ST_RUNNING;
          out_word.token_consumed   = consumed;
          out_word.last             = 1'b1;
          expect_op_next            = 1'b0;
          state_next                = S_IDLE;
        end
      end

      // Emit the status word and drop the expression
      S_STATUS: begin
        if (out_rdy) begin
          out_load                = 1'b1;
          out_word.status         = st_code;
          out_word.token_consumed = consumed;
          out_word.last           = 1'b1;
          count_next              = '0;
          open_cnt_next           = '0;
          expect_op_next          = 1'b1;
          state_next              = S_IDLE;
        end
      end

      // Push onto the stack
      S_PUSH: begin
        wr_en      = 1'b1;
        top_next   = push_val;
        count_next = count + CW'(1);
        if (push_expect) begin
          expect_op_next = 1'b1;
        end
        state_next = S_IDLE;
      end

      // Fetch the entry below the top
      S_POP_RD: begin
        rd_en      = 1'b1;
        state_next = S_POP_DO;
      end

      // Pop the top entry, emitting it unless it is a paren
      S_POP_DO: begin
        out_word.has_node         = 1'b1;
        out_word.node_is_operator = 1'b1;
        out_word.node_value       = {28'd0, top};
        out_word.status           = ST_RUNNING;
        out_word.token_consumed   = consumed;
        case (mode)
          PM_FINISH: begin
            if (out_rdy) begin
              out_load     = 1'b1;
              count_next   = cnt_m1;
              top_next     = rd_data;
              st_code_next = ST_COMPLETE;
              state_next   = more ? S_POP_RD : S_STATUS;
            end
          end
          PM_BIN: begin
            out_word.last = !(more && pop_ok);
            if (out_rdy) begin
              out_load   = 1'b1;
              count_next = cnt_m1;
              top_next   = rd_data;
              state_next = (more && pop_ok) ? S_POP_RD : S_PUSH;
            end
          end
          PM_CLOSE: begin
            out_word.last = !(more && rd_data != PAREN_MARK);
            if (out_rdy) begin
              out_load   = 1'b1;
              count_next = cnt_m1;
              top_next   = rd_data;
              if (more) begin
                mode_next  = (rd_data != PAREN_MARK) ? PM_CLOSE : PM_PAREN;
                state_next = S_POP_RD;
              end else begin
                open_cnt_next = open_cnt - CW'(1);
                state_next    = S_IDLE;
              end
            end
          end
          default: begin
            count_next    = (count != '0) ? cnt_m1 : count;
            top_next      = rd_data;
            open_cnt_next = open_cnt - CW'(1);
            state_next    = S_IDLE;
          end
        endcase
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      open_cnt  <= '0;
      expect_op <= 1'b1;
    end else begin
      state     <= state_next;
      count     <= count_next;
      open_cnt  <= open_cnt_next;
      expect_op <= expect_op_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    mode        <= mode_next;
    tok         <= tok_next;
    top         <= top_next;
    st_code     <= st_code_next;
    consumed    <= consumed_next;
    push_val    <= push_val_next;
    push_expect <= push_expect_next;
  end

  itp_ram #(
    .WIDTH (4),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (push_val),
    .rd_en   (rd_en),
    .rd_addr (cnt_m2[AW-1:0]),
    .rd_data (rd_data)
  );

  itp_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (out_load),
    .din   (out_word),
    .ready (out_rdy),
    .stall (out_stall),
    .valid (out_valid),
    .dout  (out_data)
  );

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("stack count beyond depth");
  // An open paren is counted in the cycle before its push lands
  a_open_bound: assert property (@(posedge clk) disable iff (rst)
    state != S_PUSH |-> open_cnt <= count)
    else $error("more open parens than stack entries");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    state == S_PUSH |-> count < FULL)
    else $error("push onto a full stack");
  a_load_room: assert property (@(posedge clk) disable iff (rst) out_load |-> out_rdy)
    else $error("result loaded into a busy output register");
`endif

endmodule

>>> rtl/itp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module itp_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/itp_out_reg.sv
// Output register holding one result word towards the downstream side.
module itp_out_reg
  import itp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t din,
  output logic    ready,
  input  logic    stall,
  output logic    valid,
  output result_t dout
);

  logic valid_next;

  // Free when empty or when the held word leaves this cycle
  assign ready = !valid || !stall;

  always_comb begin
    valid_next = valid;
    if (load) begin
      valid_next = 1'b1;
    end else if (!stall) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Hold payload until a new word is loaded
  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule
